// ===== rtl/reserved_shared_quota_manager_core_defines.svh =====
// Assertion macros used by the checker file of the quota manager.
`ifndef RESERVED_SHARED_QUOTA_MANAGER_CORE_DEFINES_SVH
`define RESERVED_SHARED_QUOTA_MANAGER_CORE_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define RSQM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define RSQM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rsqm_pkg.sv =====
// ----------------------------------------------------------------------------
// rsqm_pkg
// Types and constants shared by the reserved/shared quota manager modules.
// ----------------------------------------------------------------------------
package rsqm_pkg;

  localparam int NumTypes   = 11;
  localparam int NumCapRegs = 8;
  localparam int TypeLe0    = 5;
  localparam int TypeTle    = 9;
  localparam int NumPe      = 4;

  // Request codes.
  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_ALLOC  = 2'd2,
    REQ_FREE   = 2'd3
  } req_t;

  // Status codes.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_NO_SPACE  = 3'd2,
    ST_NO_POOL   = 3'd3,
    ST_UNDERFLOW = 3'd4
  } status_t;

  // Packed entry word held in the entry memory.
  typedef struct packed {
    logic [15:0] reserved;
    logic [15:0] limit;
    logic [15:0] count;
  } entry_t;

  // Per-type counter word held in the type memory.
  typedef struct packed {
    logic [15:0] in_use;
    logic [15:0] reserved;
    logic [15:0] spill_cnt;
  } type_cnt_t;

  // Capacity register that serves a resource type.
  function automatic logic [2:0] cap_reg_of(input logic [3:0] t);
    logic [2:0] r;
    case (t)
      4'd0: r = 3'd0;
      4'd1: r = 3'd1;
      4'd2: r = 3'd2;
      4'd3: r = 3'd3;
      4'd4: r = 3'd4;
      4'd5, 4'd6, 4'd7, 4'd8: r = 3'd5;
      4'd9: r = 3'd6;
      default: r = 3'd7;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] inc_sat(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic [15:0] dec_sat(input logic [15:0] v);
    return (v == 16'd0) ? v : v - 16'd1;
  endfunction

endpackage

// ===== rtl/rsqm_ram.sv =====
// ----------------------------------------------------------------------------
// rsqm_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module rsqm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/rsqm_pool_alloc.sv =====
// ----------------------------------------------------------------------------
// rsqm_pool_alloc
// LE and TLE pool bitmaps with lowest-free search, claim and release.
// ----------------------------------------------------------------------------
module rsqm_pool_alloc #(
  parameter int NUM_LE_POOLS  = 16,
  parameter int NUM_TLE_POOLS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] pe_sel,
  input  logic       is_tle,
  output logic       found,
  output logic [5:0] found_id,
  input  logic       claim,
  input  logic       release_en,
  input  logic [5:0] release_id
);

  localparam int LeW  = (NUM_LE_POOLS  < 64) ? NUM_LE_POOLS  : 64;
  localparam int TleW = (NUM_TLE_POOLS < 64) ? NUM_TLE_POOLS : 64;

  logic [63:0] le_map_r [rsqm_pkg::NumPe];
  logic [63:0] tle_map_r;
  logic [63:0] map_sel;
  logic [6:0]  lo;
  logic [6:0]  hi;

  // Lowest free id in the selected map, over the valid id range.
  always_comb begin
    map_sel  = is_tle ? tle_map_r : le_map_r[pe_sel];
    lo       = is_tle ? 7'd0 : 7'd1;
    hi       = is_tle ? 7'(TleW) : 7'(LeW);
    found    = 1'b0;
    found_id = 6'd0;
    for (int i = 63; i >= 0; i--) begin
      if (7'(i) >= lo && 7'(i) < hi && !map_sel[i]) begin
        found    = 1'b1;
        found_id = 6'(i);
      end
    end
  end

  // Bitmap updates.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < rsqm_pkg::NumPe; p++) le_map_r[p] <= '0;
      tle_map_r <= '0;
    end else if (claim) begin
      if (is_tle) tle_map_r[found_id] <= 1'b1;
      else le_map_r[pe_sel][found_id] <= 1'b1;
    end else if (release_en) begin
      if (is_tle) tle_map_r[release_id] <= 1'b0;
      else le_map_r[pe_sel][release_id] <= 1'b0;
    end
  end

endmodule

// ===== rtl/reserved_shared_quota_manager_core.sv =====
// ----------------------------------------------------------------------------
// reserved_shared_quota_manager_core
// Admission control for eleven shared resource types over many groups.
// ----------------------------------------------------------------------------
// Each request passes from the accepting edge to out_valid through the READ
// state, which reads the entry, type and group-pool memories, then the EXEC
// state, which decides and writes back, then the registered result word.
// busy is high from the accepting edge until the result cycle and low during
// it, so the next request can be accepted at the edge that ends the out_valid
// cycle; no new request is taken before the last result is presented. After
// reset a clearing pass walks the NUM_GROUPS*11-word entry memory, one entry a
// cycle, plus the 11-word type memory in parallel; busy is high throughout.
// The result word cannot be stalled by the receiver.
module reserved_shared_quota_manager_core #(
  parameter int NUM_GROUPS    = 64,
  parameter int NUM_LE_POOLS  = 16,
  parameter int NUM_TLE_POOLS = 16,
  parameter int MIN_POOL_TLES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [3:0]  in_rsrc_type,
  input  logic [5:0]  in_group_index,
  input  logic [15:0] in_reserved_count,
  input  logic [15:0] in_max_count,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [3:0]  out_pool_id,
  output logic [15:0] out_entry_in_use,
  output logic [15:0] out_shared_left,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int NumEntries = NUM_GROUPS * rsqm_pkg::NumTypes;
  localparam int EntAw      = (NumEntries > 1) ? $clog2(NumEntries) : 1;
  localparam int TypAw      = $clog2(rsqm_pkg::NumTypes);
  localparam int LeDepth    = NUM_GROUPS * rsqm_pkg::NumPe;
  localparam int LeAw       = $clog2(LeDepth);
  localparam int TleAw      = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int GAw        = 6;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EXEC
  } state_t;

  state_t state_r;
  logic [EntAw-1:0] clr_r;
  logic [15:0] cap_r [rsqm_pkg::NumCapRegs];

  // Latched request.
  logic [1:0]  req_r;
  logic [3:0]  typ_r;
  logic [5:0]  grp_r;
  logic [15:0] res_r;
  logic [15:0] mx_r;

  logic        out_valid_r;
  logic [2:0]  status_r;
  logic [3:0]  pool_r;
  logic [15:0] in_use_r;
  logic [15:0] shl_r;

  // Memory ports.
  logic              ent_we, typ_we, lep_we, tlep_we;
  logic [EntAw-1:0]  ent_waddr, ent_raddr;
  logic [TypAw-1:0]  typ_waddr, typ_raddr;
  logic [LeAw-1:0]   lep_addr;
  logic [TleAw-1:0]  tlep_addr;
  rsqm_pkg::entry_t    ent_wdata, ent_rdata;
  rsqm_pkg::type_cnt_t typ_wdata, typ_rdata;
  logic [3:0]  lep_rdata, tlep_rdata;
  logic [3:0]  pool_wdata;

  logic        acc;
  logic        valid_req;
  logic [EntAw+GAw-1:0] e_full;
  logic [1:0]  pe;
  logic        is_le, is_tle;
  logic        found;
  logic [5:0]  found_id;
  logic        claim, rel;
  logic [5:0]  rel_id;

  // Datapath decisions in the execute cycle.
  rsqm_pkg::entry_t    ent_n;
  rsqm_pkg::type_cnt_t typ_n;
  logic [15:0] cap;
  logic [15:0] shl_now, shl_n;
  logic [2:0]  st_n;
  logic [3:0]  pool_n;
  logic        wr_n;

  assign acc       = start && !busy;
  assign busy      = state_r != S_IDLE;
  assign cfg_ready = 1'b1;
  assign valid_req = (typ_r < 4'(rsqm_pkg::NumTypes)) && (32'(grp_r) < 32'(NUM_GROUPS));
  assign e_full    = (EntAw+GAw)'(grp_r) * (EntAw+GAw)'(rsqm_pkg::NumTypes)
                   + (EntAw+GAw)'(typ_r);
  assign is_le     = typ_r >= 4'(rsqm_pkg::TypeLe0) && typ_r < 4'(rsqm_pkg::TypeLe0 + 4);
  assign is_tle    = typ_r == 4'(rsqm_pkg::TypeTle);
  assign pe        = 2'(typ_r - 4'(rsqm_pkg::TypeLe0));

  assign ent_raddr = e_full[EntAw-1:0];
  assign typ_raddr = typ_r[TypAw-1:0];
  assign lep_addr  = LeAw'({grp_r, pe});
  assign tlep_addr = grp_r[TleAw-1:0];

  rsqm_ram #(.WIDTH($bits(rsqm_pkg::entry_t)), .DEPTH(NumEntries)) u_ent_ram (
    .clk(clk), .wr_en(ent_we), .wr_addr(ent_waddr), .wr_data(ent_wdata),
    .rd_addr(ent_raddr), .rd_data(ent_rdata)
  );

  rsqm_ram #(.WIDTH($bits(rsqm_pkg::type_cnt_t)), .DEPTH(rsqm_pkg::NumTypes)) u_typ_ram (
    .clk(clk), .wr_en(typ_we), .wr_addr(typ_waddr), .wr_data(typ_wdata),
    .rd_addr(typ_raddr), .rd_data(typ_rdata)
  );

  rsqm_ram #(.WIDTH(4), .DEPTH(LeDepth)) u_lep_ram (
    .clk(clk), .wr_en(lep_we), .wr_addr(lep_addr), .wr_data(pool_wdata),
    .rd_addr(lep_addr), .rd_data(lep_rdata)
  );

  rsqm_ram #(.WIDTH(4), .DEPTH(NUM_GROUPS)) u_tlep_ram (
    .clk(clk), .wr_en(tlep_we), .wr_addr(tlep_addr), .wr_data(pool_wdata),
    .rd_addr(tlep_addr), .rd_data(tlep_rdata)
  );

  rsqm_pool_alloc #(.NUM_LE_POOLS(NUM_LE_POOLS), .NUM_TLE_POOLS(NUM_TLE_POOLS)) u_pool (
    .clk(clk), .rst_n(rst_n), .pe_sel(pe), .is_tle(is_tle),
    .found(found), .found_id(found_id), .claim(claim),
    .release_en(rel), .release_id(rel_id)
  );

  // Request evaluation against the words read from memory.
  always_comb begin
    cap     = cap_r[rsqm_pkg::cap_reg_of(typ_r)];
    ent_n   = ent_rdata;
    typ_n   = typ_rdata;
    shl_now = (cap > typ_rdata.reserved) ? cap - typ_rdata.reserved : 16'd0;
    st_n    = rsqm_pkg::ST_OK;
    pool_n  = 4'd0;
    wr_n    = 1'b0;
    claim   = 1'b0;
    rel     = 1'b0;
    rel_id  = is_tle ? 6'(tlep_rdata) : 6'(lep_rdata);
    case (rsqm_pkg::req_t'(req_r))
      rsqm_pkg::REQ_ADD: begin
        if (res_r == 16'd0 && mx_r == 16'd0) begin
          ent_n = '0;
          wr_n  = 1'b1;
        end else if (is_tle && ((res_r != 16'd0 && 32'(res_r) < 32'(MIN_POOL_TLES))
                                || mx_r != res_r)) begin
          st_n = rsqm_pkg::ST_INVALID;
        end else if (res_r > shl_now || mx_r > cap) begin
          st_n = rsqm_pkg::ST_NO_SPACE;
        end else if ((is_le || is_tle) && !found) begin
          st_n = rsqm_pkg::ST_NO_POOL;
        end else begin
          claim          = is_le || is_tle;
          pool_n         = (is_le || is_tle) ? found_id[3:0] : 4'd0;
          typ_n.reserved = typ_rdata.reserved + res_r;
          ent_n.reserved = res_r;
          ent_n.limit    = mx_r;
          ent_n.count    = 16'd0;
          wr_n           = 1'b1;
        end
      end
      rsqm_pkg::REQ_REMOVE: begin
        typ_n.reserved = (typ_rdata.reserved > ent_rdata.reserved)
                       ? typ_rdata.reserved - ent_rdata.reserved : 16'd0;
        rel            = (ent_rdata.reserved != 16'd0 || ent_rdata.limit != 16'd0)
                         && (is_le || is_tle);
        ent_n.reserved = 16'd0;
        ent_n.limit    = 16'd0;
        wr_n           = 1'b1;
      end
      rsqm_pkg::REQ_ALLOC: begin
        if (ent_rdata.count < ent_rdata.reserved) begin
          ent_n.count  = ent_rdata.count + 16'd1;
          typ_n.in_use = rsqm_pkg::inc_sat(typ_rdata.in_use);
          wr_n         = 1'b1;
        end else if (ent_rdata.count < ent_rdata.limit && typ_rdata.spill_cnt < cap) begin
          ent_n.count     = ent_rdata.count + 16'd1;
          typ_n.in_use    = rsqm_pkg::inc_sat(typ_rdata.in_use);
          typ_n.spill_cnt = typ_rdata.spill_cnt + 16'd1;
          wr_n            = 1'b1;
        end else begin
          st_n = rsqm_pkg::ST_NO_SPACE;
        end
      end
      rsqm_pkg::REQ_FREE: begin
        if (ent_rdata.count == 16'd0) begin
          st_n = rsqm_pkg::ST_UNDERFLOW;
        end else begin
          if (ent_rdata.count > ent_rdata.reserved) begin
            typ_n.spill_cnt = rsqm_pkg::dec_sat(typ_rdata.spill_cnt);
          end
          typ_n.in_use = rsqm_pkg::dec_sat(typ_rdata.in_use);
          ent_n.count  = ent_rdata.count - 16'd1;
          wr_n         = 1'b1;
        end
      end
      default: st_n = rsqm_pkg::ST_OK;
    endcase
    if (!valid_req) begin
      st_n  = rsqm_pkg::ST_INVALID;
      wr_n  = 1'b0;
      claim = 1'b0;
      rel   = 1'b0;
    end
    // Pool bitmaps change only in the execute cycle.
    if (state_r != S_EXEC) begin
      claim = 1'b0;
      rel   = 1'b0;
    end
    shl_n = (cap > typ_n.reserved) ? cap - typ_n.reserved : 16'd0;
  end

  // Write ports: clearing pass or execute write-back.
  always_comb begin
    ent_we     = 1'b0;
    typ_we     = 1'b0;
    ent_waddr  = ent_raddr;
    typ_waddr  = typ_raddr;
    ent_wdata  = ent_n;
    typ_wdata  = typ_n;
    pool_wdata = found_id[3:0];
    lep_we     = 1'b0;
    tlep_we    = 1'b0;
    if (state_r == S_CLEAR) begin
      ent_we    = 1'b1;
      ent_waddr = clr_r;
      ent_wdata = '0;
      typ_we    = 32'(clr_r) < rsqm_pkg::NumTypes;
      typ_waddr = clr_r[TypAw-1:0];
      typ_wdata = '0;
    end else if (state_r == S_EXEC) begin
      ent_we  = wr_n;
      typ_we  = wr_n;
      lep_we  = claim && is_le;
      tlep_we = claim && is_tle;
    end
  end

  // Sequencer, configuration registers and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      cap_r[0] <= 16'd2048;
      cap_r[1] <= 16'd1024;
      cap_r[2] <= 16'd512;
      cap_r[3] <= 16'd2048;
      cap_r[4] <= 16'd2048;
      cap_r[5] <= 16'd16384;
      cap_r[6] <= 16'd2048;
      cap_r[7] <= 16'd1024;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_valid) begin
        cap_r[cfg_index] <= cfg_data;
      end
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + EntAw'(1);
          if (32'(clr_r) == NumEntries - 1) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (acc) state_r <= S_READ;
        end
        S_READ: state_r <= S_EXEC;
        S_EXEC: begin
          state_r     <= S_IDLE;
          out_valid_r <= 1'b1;
          status_r    <= st_n;
          pool_r      <= valid_req ? pool_n : 4'd0;
          in_use_r    <= valid_req ? ent_n.count : 16'd0;
          shl_r       <= valid_req ? shl_n : 16'd0;
        end
        default: state_r <= S_IDLE;
      endcase
      if (acc) begin
        req_r <= in_req_type;
        typ_r <= in_rsrc_type;
        grp_r <= in_group_index;
        res_r <= in_reserved_count;
        mx_r  <= in_max_count;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_pool_id      = pool_r;
  assign out_entry_in_use = in_use_r;
  assign out_shared_left  = shl_r;

endmodule

// ===== rtl/rsqm_checker.sv =====
// ----------------------------------------------------------------------------
// rsqm_checker
// Port-level checks of the quota manager, bound to the top level.
// ----------------------------------------------------------------------------
`include "reserved_shared_quota_manager_core_defines.svh"

module rsqm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [2:0]  out_status,
  input logic [3:0]  out_pool_id
);

  // An accepted request keeps the block busy in the following cycle.
  `RSQM_ASSERT_NEXT(a_busy_after_start, clk, rst_n, start && !busy, busy, "not busy after start")
  // A result appears only while the block is idle, never while busy.
  `RSQM_ASSERT_IMPL(a_result_ends_busy, clk, rst_n, out_valid, !busy, "result while busy")
  // Status codes stay within the defined set.
  `RSQM_ASSERT_IMPL(a_status_range, clk, rst_n, out_valid,
                    out_status <= rsqm_pkg::ST_UNDERFLOW, "bad status")
  // Failed requests carry no pool id.
  `RSQM_ASSERT_IMPL(a_pool_on_ok, clk, rst_n, out_valid && out_status != rsqm_pkg::ST_OK,
                    out_pool_id == 4'd0, "pool id on failure")

endmodule

bind reserved_shared_quota_manager_core rsqm_checker u_rsqm_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_status(out_status), .out_pool_id(out_pool_id)
);

// ===== tb/tb_reserved_shared_quota_manager_core.sv =====
// ----------------------------------------------------------------------------
// Testbench for reserved_shared_quota_manager_core
// Drives add, remove, alloc and free requests through the start/busy port
// and checks each result word against a predictor of the quota counters, or
// the table for typed rows. A directed table comes first, then pool exhaustion
// and random requests, under several capacity settings that include the extremes.
// ----------------------------------------------------------------------------
module tb_reserved_shared_quota_manager_core;
  import rsqm_pkg::*;

  localparam int NGroups       = 64;
  localparam int NLePools      = 16;
  localparam int NTlePools     = 16;
  localparam int MinTles       = 8;
  localparam int NEntries      = NGroups * NumTypes;
  localparam int WatchdogLimit = 4000;
  localparam int ItemsPerPhase = 80;

  typedef struct packed {
    logic [2:0]  st;
    logic [3:0]  pool;
    logic [15:0] used;
    logic [15:0] left;
  } quota_result_t;

  typedef struct packed {
    req_t        rq;
    logic [3:0]  t;
    logic [5:0]  g;
    logic [15:0] rc;
    logic [15:0] mc;
    logic        typed;
    logic [2:0]  st;
    logic [3:0]  pool;
    logic [15:0] used;
    logic [15:0] left;
  } step_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_req_type;
  logic [3:0]  in_rsrc_type;
  logic [5:0]  in_group_index;
  logic [15:0] in_reserved_count;
  logic [15:0] in_max_count;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [3:0]  out_pool_id;
  logic [15:0] out_entry_in_use;
  logic [15:0] out_shared_left;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  reserved_shared_quota_manager_core #(
    .NUM_GROUPS(NGroups),
    .NUM_LE_POOLS(NLePools),
    .NUM_TLE_POOLS(NTlePools),
    .MIN_POOL_TLES(MinTles)
  ) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_rsrc_type(in_rsrc_type),
    .in_group_index(in_group_index), .in_reserved_count(in_reserved_count),
    .in_max_count(in_max_count), .out_valid(out_valid), .out_status(out_status),
    .out_pool_id(out_pool_id), .out_entry_in_use(out_entry_in_use),
    .out_shared_left(out_shared_left), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state: capacities, per-type and per-entry counters, pool maps.
  logic [15:0]          cap_q [NumCapRegs];
  logic [15:0]          type_rsv [NumTypes];
  logic [15:0]          type_shared [NumTypes];
  logic [15:0]          ent_rsv [NEntries];
  logic [15:0]          ent_lim [NEntries];
  logic [15:0]          ent_cnt [NEntries];
  logic [NLePools-1:0]  le_map [NumPe];
  logic [NTlePools-1:0] tle_map;
  logic [3:0]           grp_le_pool [NGroups][NumPe];
  logic [3:0]           grp_tle_pool [NGroups];

  quota_result_t pending_words[$];
  int            failures;
  int            items_sent;
  int            words_checked;
  int            status_seen [8];
  int            idle_cycles;
  bit            allow_gaps;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Capacity register that serves a resource type.
  function automatic int cap_slot(input logic [3:0] t);
    if (t < 4'd5) begin
      return int'(t);
    end else if (t < 4'd9) begin
      return 5;
    end else if (t == 4'd9) begin
      return 6;
    end
    return 7;
  endfunction

  function automatic logic [15:0] shared_room(input logic [3:0] t);
    logic [15:0] c;
    c = cap_q[cap_slot(t)];
    return (c > type_rsv[t]) ? c - type_rsv[t] : 16'd0;
  endfunction

  function automatic void clear_quota_state();
    cap_q = '{16'd2048, 16'd1024, 16'd512, 16'd2048, 16'd2048, 16'd16384, 16'd2048,
              16'd1024};
    for (int i = 0; i < NumTypes; i++) begin
      type_rsv[i] = '0;
      type_shared[i] = '0;
    end
    for (int i = 0; i < NEntries; i++) begin
      ent_rsv[i] = '0;
      ent_lim[i] = '0;
      ent_cnt[i] = '0;
    end
    for (int i = 0; i < NumPe; i++) le_map[i] = '0;
    tle_map = '0;
    for (int i = 0; i < NGroups; i++) begin
      grp_tle_pool[i] = '0;
      for (int j = 0; j < NumPe; j++) grp_le_pool[i][j] = '0;
    end
  endfunction

  // Apply one request to the quota state and return the result word it gives.
  function automatic quota_result_t apply_quota_request(input req_t rq, input logic [3:0] t,
      input logic [5:0] g, input logic [15:0] rc, input logic [15:0] mc);
    quota_result_t r;
    int            e;
    int            pe;
    int            id;
    bit            is_le;
    bit            is_tle;
    bit            live;
    r = '0;
    if (t >= NumTypes) begin
      r.st = ST_INVALID;
      return r;
    end
    e = int'(g) * NumTypes + int'(t);
    is_le = (t >= TypeLe0) && (t < TypeLe0 + NumPe);
    is_tle = (t == TypeTle);
    pe = is_le ? int'(t) - TypeLe0 : 0;
    r.st = ST_OK;
    case (rq)
      REQ_ADD: begin
        if (rc == 0 && mc == 0) begin
          ent_rsv[e] = '0;
          ent_lim[e] = '0;
          ent_cnt[e] = '0;
        end else if (is_tle && ((rc != 0 && rc < MinTles) || mc != rc)) begin
          r.st = ST_INVALID;
        end else if (rc > shared_room(t) || mc > cap_q[cap_slot(t)]) begin
          r.st = ST_NO_SPACE;
        end else begin
          id = -1;
          if (is_le) begin
            for (int i = NLePools - 1; i >= 1; i--) if (!le_map[pe][i]) id = i;
          end else if (is_tle) begin
            for (int i = NTlePools - 1; i >= 0; i--) if (!tle_map[i]) id = i;
          end
          if ((is_le || is_tle) && id < 0) begin
            r.st = ST_NO_POOL;
          end else begin
            if (is_le) begin
              le_map[pe][id] = 1'b1;
              grp_le_pool[g][pe] = id[3:0];
              r.pool = id[3:0];
            end else if (is_tle) begin
              tle_map[id] = 1'b1;
              grp_tle_pool[g] = id[3:0];
              r.pool = id[3:0];
            end
            type_rsv[t] = type_rsv[t] + rc;
            ent_rsv[e] = rc;
            ent_lim[e] = mc;
            ent_cnt[e] = '0;
          end
        end
      end
      REQ_REMOVE: begin
        live = (ent_rsv[e] != 0) || (ent_lim[e] != 0);
        type_rsv[t] = (type_rsv[t] > ent_rsv[e]) ? type_rsv[t] - ent_rsv[e] : 16'd0;
        if (live && is_le) begin
          le_map[pe][grp_le_pool[g][pe]] = 1'b0;
        end else if (live && is_tle) begin
          tle_map[grp_tle_pool[g]] = 1'b0;
        end
        ent_rsv[e] = '0;
        ent_lim[e] = '0;
      end
      REQ_ALLOC: begin
        if (ent_cnt[e] < ent_rsv[e]) begin
          ent_cnt[e] = ent_cnt[e] + 16'd1;
        end else if (ent_cnt[e] < ent_lim[e] && type_shared[t] < cap_q[cap_slot(t)]) begin
          ent_cnt[e] = ent_cnt[e] + 16'd1;
          type_shared[t] = type_shared[t] + 16'd1;
        end else begin
          r.st = ST_NO_SPACE;
        end
      end
      default: begin
        if (ent_cnt[e] == 0) begin
          r.st = ST_UNDERFLOW;
        end else begin
          if (ent_cnt[e] > ent_rsv[e] && type_shared[t] != 0)
            type_shared[t] = type_shared[t] - 16'd1;
          ent_cnt[e] = ent_cnt[e] - 16'd1;
        end
      end
    endcase
    r.used = ent_cnt[e];
    r.left = shared_room(t);
    return r;
  endfunction

  // Directed table; rows marked typed carry a result read straight off the spec.
  localparam int NumRows = 25;
  step_row_t plan [NumRows] = '{
    '{REQ_FREE,   4'd0,  6'd0,  16'd0,    16'd0,    1'b1, ST_UNDERFLOW, 4'd0, 16'd0, 16'd2048},
    '{REQ_ALLOC,  4'd0,  6'd0,  16'd0,    16'd0,    1'b1, ST_NO_SPACE,  4'd0, 16'd0, 16'd2048},
    '{REQ_ADD,    4'd15, 6'd63, 16'hFFFF, 16'hFFFF, 1'b1, ST_INVALID,   4'd0, 16'd0, 16'd0},
    '{REQ_ADD,    4'd11, 6'd0,  16'd0,    16'd0,    1'b1, ST_INVALID,   4'd0, 16'd0, 16'd0},
    '{REQ_ADD,    4'd0,  6'd0,  16'd0,    16'd0,    1'b1, ST_OK,        4'd0, 16'd0, 16'd2048},
    '{REQ_ADD,    4'd1,  6'd1,  16'hFFFF, 16'hFFFF, 1'b1, ST_NO_SPACE,  4'd0, 16'd0, 16'd1024},
    '{REQ_ADD,    4'd9,  6'd2,  16'd4,    16'd4,    1'b1, ST_INVALID,   4'd0, 16'd0, 16'd2048},
    '{REQ_ADD,    4'd9,  6'd2,  16'd8,    16'd9,    1'b1, ST_INVALID,   4'd0, 16'd0, 16'd2048},
    '{REQ_ADD,    4'd9,  6'd2,  16'd8,    16'd8,    1'b1, ST_OK,        4'd0, 16'd0, 16'd2040},
    '{REQ_ADD,    4'd5,  6'd3,  16'd2,    16'd4,    1'b1, ST_OK,        4'd1, 16'd0, 16'd16382},
    '{REQ_ALLOC,  4'd5,  6'd3,  16'd0,    16'd0,    1'b0, ST_OK, 4'd0, 16'd0, 16'd0},
    '{REQ_ALLOC,  4'd5,  6'd3,  16'd0,    16'd0,    1'b0, ST_OK, 4'd0, 16'd0, 16'd0},
    '{REQ_ALLOC,  4'd5,  6'd3,  16'd0,    16'd0,    1'b0, ST_OK, 4'd0, 16'd0, 16'd0},
    '{REQ_ALLOC,  4'd5,  6'd3,  16'd0,    16'd0,    1'b0, ST_OK, 4'd0, 16'd0, 16'd0},
    '{REQ_ALLOC,  4'd5,  6'd3,  16'd0,    16'd0,    1'b0, ST_OK, 4'd0, 16'd0, 16'd0},
    '{REQ_FREE,   4'd5,  6'd3,  16'd0,    16'd0,    1'b0, ST_OK, 4'd0, 16'd0, 16'd0},
    '{REQ_REMOVE, 4'd5,  6'd3,  16'd0,    16'd0,    1'b0, ST_OK, 4'd0, 16'd0, 16'd0},
    '{REQ_REMOVE, 4'd9,  6'd2,  16'd0,    16'd0,    1'b0, ST_OK, 4'd0, 16'd0, 16'd0},
    '{REQ_ADD,    4'd10, 6'd63, 16'd1024, 16'd1024, 1'b1, ST_OK,        4'd0, 16'd0, 16'd0},
    '{REQ_ALLOC,  4'd10, 6'd63, 16'd0,    16'd0,    1'b0, ST_OK, 4'd0, 16'd0, 16'd0},
    '{REQ_ADD,    4'd2,  6'd4,  16'd0,    16'd512,  1'b1, ST_OK,        4'd0, 16'd0, 16'd512},
    '{REQ_ALLOC,  4'd2,  6'd4,  16'd0,    16'd0,    1'b0, ST_OK, 4'd0, 16'd0, 16'd0},
    '{REQ_ADD,    4'd8,  6'd5,  16'hFFFF, 16'd0,    1'b1, ST_NO_SPACE,  4'd0, 16'd0, 16'd16384},
    '{REQ_ADD,    4'd6,  6'd7,  16'd0,    16'hFFFF, 1'b1, ST_NO_SPACE,  4'd0, 16'd0, 16'd16384},
    '{REQ_REMOVE, 4'd0,  6'd0,  16'd0,    16'd0,    1'b0, ST_OK, 4'd0, 16'd0, 16'd0}
  };

  // Send one request word; entered and left at a falling edge.
  task automatic send_request(input req_t rq, input logic [3:0] t, input logic [5:0] g,
      input logic [15:0] rc, input logic [15:0] mc, input bit typed,
      input quota_result_t want);
    quota_result_t r;
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    start = 1'b1;
    in_req_type = rq;
    in_rsrc_type = t;
    in_group_index = g;
    in_reserved_count = rc;
    in_max_count = mc;
    do @(posedge clk); while (busy);
    r = apply_quota_request(rq, t, g, rc, mc);
    pending_words.push_back(typed ? want : r);
    items_sent++;
    @(negedge clk);
    start = 1'b0;
  endtask

  // Wait until every expected word has come back and the block has settled.
  task automatic wait_drained();
    while (pending_words.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_capacity(input int idx, input logic [15:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx[2:0];
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    cap_q[idx] = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_random_request();
    req_t        rq;
    logic [3:0]  t;
    logic [5:0]  g;
    logic [15:0] rc;
    logic [15:0] mc;
    int          pick;
    g = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 7));
    t = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15)) : 4'($urandom_range(0, 10));
    pick = $urandom_range(0, 9);
    if (pick < 2) rq = REQ_ADD;
    else if (pick == 2) rq = REQ_REMOVE;
    else if (pick < 7) rq = REQ_ALLOC;
    else rq = REQ_FREE;
    case ($urandom_range(0, 7))
      0: rc = 16'($urandom);
      1: rc = '0;
      default: rc = 16'($urandom_range(0, 24));
    endcase
    case ($urandom_range(0, 5))
      0: mc = 16'($urandom);
      1: mc = rc;
      default: mc = rc + 16'($urandom_range(0, 8));
    endcase
    // Trigger list entries mostly get well-formed limits.
    if (t == TypeTle && $urandom_range(0, 4) != 0) begin
      rc = 16'($urandom_range(MinTles, 24));
      mc = rc;
    end
    send_request(rq, t, g, rc, mc, 1'b0, '0);
  endtask

  // Result word checker.
  always @(posedge clk) begin
    quota_result_t w;
    if (rst_n && out_valid) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected result word status %0d", $time, out_status);
        failures++;
      end else begin
        w = pending_words.pop_front();
        words_checked++;
        status_seen[out_status]++;
        if (out_status !== w.st) begin
          $display("%0t: status expected %0d actual %0d", $time, w.st, out_status);
          failures++;
        end
        if (out_pool_id !== w.pool) begin
          $display("%0t: pool_id expected %0d actual %0d", $time, w.pool, out_pool_id);
          failures++;
        end
        if (out_entry_in_use !== w.used) begin
          $display("%0t: entry_in_use expected %0d actual %0d", $time, w.used,
                   out_entry_in_use);
          failures++;
        end
        if (out_shared_left !== w.left) begin
          $display("%0t: shared_left expected %0d actual %0d", $time, w.left,
                   out_shared_left);
          failures++;
        end
      end
    end
  end

  // Watchdog on cycles in which no word moves on any port.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: no progress for %0d cycles", $time, WatchdogLimit);
      $display("Verification failed");
      $finish;
    end
  end

  // Main sequence.
  initial begin
    quota_result_t want;
    rst_n = 1'b0;
    start = 1'b0;
    in_req_type = REQ_ADD;
    in_rsrc_type = '0;
    in_group_index = '0;
    in_reserved_count = '0;
    in_max_count = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    failures = 0;
    items_sent = 0;
    words_checked = 0;
    idle_cycles = 0;
    allow_gaps = 1'b1;
    for (int i = 0; i < 8; i++) status_seen[i] = 0;
    clear_quota_state();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table.
    foreach (plan[i]) begin
      want = '{plan[i].st, plan[i].pool, plan[i].used, plan[i].left};
      send_request(plan[i].rq, plan[i].t, plan[i].g, plan[i].rc, plan[i].mc,
                   plan[i].typed, want);
    end

    // Exhaust the trigger and list entry pools, then hand them back.
    for (int k = 0; k <= NTlePools; k++)
      send_request(REQ_ADD, 4'd9, 6'(k + 8), 16'd8, 16'd8, 1'b0, '0);
    for (int k = 0; k < NLePools; k++)
      send_request(REQ_ADD, 4'd7, 6'(k + 8), 16'd0, 16'd1, 1'b0, '0);
    for (int k = 0; k <= NTlePools; k++) begin
      send_request(REQ_REMOVE, 4'd9, 6'(k + 8), 16'd0, 16'd0, 1'b0, '0);
      send_request(REQ_REMOVE, 4'd7, 6'(k + 8), 16'd0, 16'd0, 1'b0, '0);
    end

    // Random requests under default, random, all-zero and all-ones capacities.
    for (int ph = 0; ph < 4; ph++) begin
      if (ph > 0) begin
        wait_drained();
        for (int r = 0; r < NumCapRegs; r++) begin
          case (ph)
            1: write_capacity(r, 16'($urandom_range(0, 64)));
            2: write_capacity(r, 16'd0);
            default: write_capacity(r, 16'hFFFF);
          endcase
        end
      end
      allow_gaps = (ph != 3);
      repeat (ItemsPerPhase) send_random_request();
    end

    wait_drained();
    $display("Sent %0d request words, checked %0d results over four capacity settings.",
             items_sent, words_checked);
    $display("Status mix ok/invalid/no-space/no-pool/underflow: %0d/%0d/%0d/%0d/%0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4]);
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
